[rtl/jacobi_sn_nome_product_macros.svh]
// ----------------------------------------------------------------------------
// jacobi_sn_nome_product_macros
// assertion macros used by the top rtl file of the sn nome product block
// ----------------------------------------------------------------------------
`ifndef JACOBI_SN_NOME_PRODUCT_MACROS_SVH
`define JACOBI_SN_NOME_PRODUCT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define JSNP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define JSNP_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/jsnp_pkg.sv]
// ----------------------------------------------------------------------------
// jsnp_pkg
// types, constants and tables of the jacobi sn nome product block
// ----------------------------------------------------------------------------
`default_nettype none

package jsnp_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int TOL_BITS      = 21;
    localparam int LIMIT_BITS    = 7;
    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_W      = 34;
    localparam int CCNT_W        = 5;

    localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(4);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(100);

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = CORDIC_W'(652032874);
    localparam logic [29:0]                TWO_OVER_PI_Q30 = 30'd683565276;
    localparam logic signed [63:0]         SATV            = 64'sh3FFF_FFFF_FFFF_FFFF;

    // register indexes on the configuration port
    typedef enum logic [0:0] {
        REG_TOLERANCE  = 1'b0,
        REG_ITER_LIMIT = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOME   = 2'd1,
        STAT_NOCONV = 2'd2
    } t_status;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    // product shift: fraction bits of q2 format, of q8 format, or 30
    typedef enum logic [1:0] {
        SH_FRAC = 2'd0,
        SH_Q8   = 2'd1,
        SH_Q30  = 2'd2
    } t_shift;

    typedef struct packed {
        t_op    op;
        t_shift shift;
    } t_arith_ctl;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ADIV, ST_COR_S, ST_COR_C, ST_M0A, ST_M0B, ST_QQ, ST_CHK,
        ST_R_DIV, ST_R_SQ, ST_NUM_T, ST_NUM, ST_DEN_T, ST_DEN, ST_R_NUM,
        ST_R_DEN, ST_M_UPD, ST_Q1, ST_Q2, ST_OUT
    } t_state;

    // arctangent table, 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] arc_tab(input logic [CCNT_W-1:0] i);
        int v;
        begin
            case (i)
                5'd0:  v = 536870912;
                5'd1:  v = 316933406;
                5'd2:  v = 167458907;
                5'd3:  v = 85004756;
                5'd4:  v = 42667331;
                5'd5:  v = 21354465;
                5'd6:  v = 10679838;
                5'd7:  v = 5340245;
                5'd8:  v = 2670163;
                5'd9:  v = 1335087;
                5'd10: v = 667544;
                5'd11: v = 333772;
                5'd12: v = 166886;
                5'd13: v = 83443;
                5'd14: v = 41722;
                5'd15: v = 20861;
                5'd16: v = 10430;
                5'd17: v = 5215;
                5'd18: v = 2608;
                5'd19: v = 1304;
                5'd20: v = 652;
                5'd21: v = 326;
                5'd22: v = 163;
                5'd23: v = 81;
                5'd24: v = 41;
                5'd25: v = 20;
                5'd26: v = 10;
                5'd27: v = 5;
                5'd28: v = 3;
                5'd29: v = 1;
                default: v = 0;
            endcase
            return CORDIC_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/jsnp_arith.sv]
// ----------------------------------------------------------------------------
// jsnp_arith
// shared multi-cycle multiply and divide unit on signed operands, computed in sign-magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module jsnp_arith #(
    parameter int WORD_BITS = jsnp_pkg::WORD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  jsnp_pkg::t_arith_ctl          i_ctl,
    input  wire logic signed [63:0]       i_a,
    input  wire logic signed [63:0]       i_b,
    output logic                          o_done,
    output logic signed [63:0]            o_result,
    output logic [WORD_BITS+60:0]         o_quot
);
    import jsnp_pkg::*;

    localparam int FB = WORD_BITS - 2;
    localparam int GB = WORD_BITS - 8;
    localparam int QW = 63 + FB;
    localparam int CW = $clog2(QW + 1);

    logic                  r_busy;
    logic                  r_done;
    t_op                   r_op;
    t_shift                r_shift;
    logic [CW-1:0]         r_cnt;
    logic                  r_neg;
    logic                  r_sign_a;
    logic                  r_zero_a;
    logic                  r_zero_div;
    logic [62:0]           r_ua;
    logic [62:0]           r_ub;
    logic [127:0]          r_acc;
    logic [QW-1:0]         r_num;
    logic [QW-1:0]         r_quot;
    logic [62:0]           r_rem;

    logic [63:0]           w_ma;
    logic [63:0]           w_mb;
    logic [31:0]           w_pa;
    logic [31:0]           w_pb;
    logic [63:0]           w_pp;
    logic [127:0]          w_pp_sh;
    logic [63:0]           w_trial;
    logic                  w_fits;
    logic [127:0]          w_prod_sh;
    logic [62:0]           w_mag;
    logic                  w_sat;
    logic                  w_last;

    // operand magnitudes
    assign w_ma = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_mb = i_b[63] ? 64'(-i_b) : 64'(i_b);

    // one 32x32 partial product per cycle
    assign w_pa    = r_cnt[1] ? {1'b0, r_ua[62:32]} : r_ua[31:0];
    assign w_pb    = r_cnt[0] ? {1'b0, r_ub[62:32]} : r_ub[31:0];
    assign w_pp    = w_pa * w_pb;
    assign w_pp_sh = {64'd0, w_pp} << (7'd32 * (7'(r_cnt[1]) + 7'(r_cnt[0])));

    // one restoring quotient bit per cycle
    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_fits  = w_trial >= {1'b0, r_ub};

    // last busy cycle of the running operation
    assign w_last = (r_op == OP_MUL) ? (r_cnt == CW'(3))
                                     : (r_zero_div || r_cnt == CW'(QW - 1));

    // final shift and saturation
    always_comb begin
        case (r_shift)
            SH_FRAC: w_prod_sh = r_acc >> FB;
            SH_Q8:   w_prod_sh = r_acc >> GB;
            SH_Q30:  w_prod_sh = r_acc >> 30;
            default: w_prod_sh = r_acc;
        endcase
        if (r_op == OP_MUL) begin
            w_sat = |w_prod_sh[127:62];
            w_mag = w_prod_sh[62:0];
        end else begin
            w_sat = |r_quot[QW-1:62];
            w_mag = r_quot[62:0];
        end
        if (r_op == OP_DIV && r_zero_div) begin
            if (r_zero_a) o_result = '0;
            else          o_result = r_sign_a ? -SATV : SATV;
        end else if (w_sat) begin
            o_result = r_neg ? -SATV : SATV;
        end else begin
            o_result = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_done <= w_last;
            if (w_last) r_busy <= 1'b0;
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op       <= i_ctl.op;
            r_shift    <= i_ctl.shift;
            r_ua       <= w_ma[62:0];
            r_ub       <= w_mb[62:0];
            r_neg      <= i_a[63] ^ i_b[63];
            r_sign_a   <= i_a[63];
            r_zero_a   <= (w_ma == 64'd0);
            r_zero_div <= (w_mb == 64'd0);
            r_acc      <= '0;
            r_num      <= {w_ma[62:0], {FB{1'b0}}};
            r_quot     <= '0;
            r_rem      <= '0;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                r_acc <= r_acc + w_pp_sh;
            end else begin
                r_num  <= {r_num[QW-2:0], 1'b0};
                r_quot <= {r_quot[QW-2:0], w_fits};
                r_rem  <= w_fits ? 63'(w_trial - {1'b0, r_ub}) : w_trial[62:0];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/jacobi_sn_nome_product.sv]
// ----------------------------------------------------------------------------
// jacobi_sn_nome_product
// jacobi sn(u,k) from the nome product, fixed point, one shared mul/div unit
// ----------------------------------------------------------------------------
// Each item carries u (Q8.24), K (unsigned Q7.24) and q (Q2.30) and yields one
// result item with sn in Q2.30 and a status (0 converged, 1 |q| >= 1, 2 no
// convergence, result 0 on failure). The block takes one item at a time.
// Each operation on the shared unit holds its state through the issue, the
// busy time of the unit and the collection of the result. Setup is the accept,
// the angle divide, two 30-step cordic runs and three multiplies. A full
// product pass is one check state, two divides and nine multiplies; the pass
// that converges stops after its seventh multiply. An item that runs out of
// passes leaves from the check state, and |q| >= 1 goes from the accept
// straight to the output state. The output state waits while an earlier
// result item is still held by the consumer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jacobi_sn_nome_product_macros.svh"

module jacobi_sn_nome_product #(
    parameter int WORD_BITS = jsnp_pkg::WORD_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration writes
    input  wire                                   i_cfg_wr_en,
    input  wire                                   i_cfg_index,
    input  wire [jsnp_pkg::TOL_BITS-1:0]          i_cfg_data,
    // input items
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // argument_u, quarter_period, nome (from bit 0 up)
    input  wire [((3*WORD_BITS+6)/8)*8-1:0]       i_s_axis_tdata,
    // result items
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // sn_value
    output logic [((WORD_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    // status
    output logic [1:0]                            o_m_axis_tuser
);
    import jsnp_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int FB     = W - 2;
    localparam int QW     = 63 + FB;
    localparam int LSH    = (FB >= 30) ? FB - 30 : 0;
    localparam int RSH    = (FB < 30) ? 30 - FB : 0;
    localparam int PSH_R  = (W >= 32) ? W - 32 : 0;
    localparam int PSH_L  = (W < 32) ? 32 - W : 0;
    localparam int ODW    = ((W + 7) / 8) * 8;
    localparam logic signed [63:0] ONEV  = 64'sd1 <<< FB;
    localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< (W - 1));

    t_state                      r_state;
    t_state                      n_state;
    logic                        r_issued;
    logic [TOL_BITS-1:0]         r_tol;
    logic [LIMIT_BITS-1:0]       r_limit;
    logic [LIMIT_BITS-1:0]       r_n;
    logic signed [W-1:0]         r_u;
    logic [W-2:0]                r_k;
    logic signed [W-1:0]         r_q;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [CORDIC_W-1:0]  r_z;
    logic [CCNT_W-1:0]           r_ccnt;
    logic                        r_flip;
    logic [31:0]                 r_p32;
    logic signed [63:0]          r_s;
    logic signed [63:0]          r_c;
    logic signed [63:0]          r_m;
    logic signed [63:0]          r_t;
    logic signed [63:0]          r_qq;
    logic signed [63:0]          r_q1;
    logic signed [63:0]          r_q2;
    logic signed [63:0]          r_r;
    logic signed [63:0]          r_num;
    logic signed [63:0]          r_den;
    logic signed [W-1:0]         r_res_val;
    t_status                     r_res_stat;
    logic                        r_ovalid;
    logic [W-1:0]                r_odata;
    t_status                     r_ostat;

    logic                        w_accept;
    logic                        w_out_load;
    logic signed [W-1:0]         w_in_u;
    logic [W-2:0]                w_in_k;
    logic signed [W-1:0]         w_in_q;
    logic [W:0]                  w_in_qmag;
    logic                        w_nome_bad;
    logic                        w_op_state;
    logic                        w_start;
    t_arith_ctl                  w_ctl;
    logic signed [63:0]          w_a;
    logic signed [63:0]          w_b;
    logic                        w_done;
    logic signed [63:0]          w_res;
    logic [QW-1:0]               w_quot;
    logic [W-1:0]                w_ph;
    logic [63:0]                 w_p64;
    logic [31:0]                 w_p32;
    logic [31:0]                 w_p32_dbl;
    logic signed [CORDIC_W-1:0]  w_dx;
    logic signed [CORDIC_W-1:0]  w_dy;
    logic signed [CORDIC_W-1:0]  w_x_nx;
    logic signed [CORDIC_W-1:0]  w_y_nx;
    logic signed [CORDIC_W-1:0]  w_z_nx;
    logic signed [CORDIC_W-1:0]  w_s_fin;
    logic signed [CORDIC_W-1:0]  w_c_fin;
    logic signed [63:0]          w_s_conv;
    logic signed [63:0]          w_c_conv;
    logic                        w_cor_last;
    logic signed [63:0]          w_one_diff;
    logic [63:0]                 w_diff_mag;
    logic                        w_conv;
    logic signed [63:0]          w_m_clip;
    logic signed [63:0]          w_comb;

    // input unpacking and nome range check
    assign w_in_u     = i_s_axis_tdata[W-1:0];
    assign w_in_k     = i_s_axis_tdata[2*W-2:W];
    assign w_in_q     = i_s_axis_tdata[3*W-2:2*W-1];
    assign w_in_qmag  = w_in_q[W-1] ? (W+1)'(-$signed({w_in_q[W-1], w_in_q}))
                                    : (W+1)'({w_in_q[W-1], w_in_q});
    assign w_nome_bad = w_in_qmag >= ((W+1)'(1) << FB);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_OUT) && (!r_ovalid || i_m_axis_tready);

    // shared multiply and divide unit
    jsnp_arith #(
        .WORD_BITS (WORD_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_ctl    (w_ctl),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_done),
        .o_result (w_res),
        .o_quot   (w_quot)
    );

    // phase of u/K in quarter turns, scaled to 32 bits per turn
    assign w_ph      = r_u[W-1] ? W'(-w_quot[W-1:0]) : w_quot[W-1:0];
    assign w_p64     = (64'(w_ph) >> PSH_R) << PSH_L;
    assign w_p32     = w_p64[31:0];
    assign w_p32_dbl = {r_p32[30:0], 1'b0};

    // one cordic rotation step
    assign w_dx       = r_y >>> r_ccnt;
    assign w_dy       = r_x >>> r_ccnt;
    assign w_x_nx     = r_z[CORDIC_W-1] ? r_x + w_dx : r_x - w_dx;
    assign w_y_nx     = r_z[CORDIC_W-1] ? r_y - w_dy : r_y + w_dy;
    assign w_z_nx     = r_z[CORDIC_W-1] ? r_z + arc_tab(r_ccnt) : r_z - arc_tab(r_ccnt);
    assign w_cor_last = (r_ccnt == CCNT_W'(CORDIC_STEPS - 1));
    assign w_s_fin    = r_flip ? -w_y_nx : w_y_nx;
    assign w_c_fin    = r_flip ? -w_x_nx : w_x_nx;
    assign w_s_conv   = (64'(w_s_fin) <<< LSH) >>> RSH;
    assign w_c_conv   = (64'(w_c_fin) <<< LSH) >>> RSH;

    // convergence test on the pass ratio and output clipping
    assign w_one_diff = ONEV - r_r;
    assign w_diff_mag = w_one_diff[63] ? 64'(-w_one_diff) : 64'(w_one_diff);
    assign w_conv     = w_diff_mag < 64'(r_tol);
    assign w_m_clip   = (w_res > OUT_HI) ? OUT_HI : ((w_res < OUT_LO) ? OUT_LO : w_res);
    assign w_comb     = ONEV - (r_t <<< 1) + w_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = w_nome_bad ? ST_OUT : ST_ADIV;
            ST_ADIV:  if (w_done) n_state = ST_COR_S;
            ST_COR_S: if (w_cor_last) n_state = ST_COR_C;
            ST_COR_C: if (w_cor_last) n_state = ST_M0A;
            ST_M0A:   if (w_done) n_state = ST_M0B;
            ST_M0B:   if (w_done) n_state = ST_QQ;
            ST_QQ:    if (w_done) n_state = ST_CHK;
            ST_CHK:   n_state = (r_n >= r_limit) ? ST_OUT : ST_R_DIV;
            ST_R_DIV: if (w_done) n_state = ST_R_SQ;
            ST_R_SQ:  if (w_done) n_state = ST_NUM_T;
            ST_NUM_T: if (w_done) n_state = ST_NUM;
            ST_NUM:   if (w_done) n_state = ST_DEN_T;
            ST_DEN_T: if (w_done) n_state = ST_DEN;
            ST_DEN:   if (w_done) n_state = ST_R_NUM;
            ST_R_NUM: if (w_done) n_state = ST_R_DEN;
            ST_R_DEN: if (w_done) n_state = ST_M_UPD;
            ST_M_UPD: if (w_done) n_state = w_conv ? ST_OUT : ST_Q1;
            ST_Q1:    if (w_done) n_state = ST_Q2;
            ST_Q2:    if (w_done) n_state = ST_CHK;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // operation issued to the shared unit in each state
    always_comb begin
        w_op_state = 1'b1;
        w_ctl      = '{op: OP_MUL, shift: SH_FRAC};
        w_a        = '0;
        w_b        = '0;
        case (r_state)
            ST_ADIV: begin
                w_ctl = '{op: OP_DIV, shift: SH_FRAC};
                w_a   = 64'(r_u);
                w_b   = 64'({1'b0, r_k});
            end
            ST_M0A: begin
                w_ctl.shift = SH_Q8;
                w_a         = r_s;
                w_b         = 64'({1'b0, r_k});
            end
            ST_M0B: begin
                w_ctl.shift = SH_Q30;
                w_a         = r_t;
                w_b         = {34'd0, TWO_OVER_PI_Q30};
            end
            ST_QQ: begin
                w_a = 64'(r_q);
                w_b = 64'(r_q);
            end
            ST_R_DIV: begin
                w_ctl.op = OP_DIV;
                w_a      = ONEV - r_q1;
                w_b      = ONEV - r_q2;
            end
            ST_R_SQ: begin
                w_a = r_r;
                w_b = r_r;
            end
            ST_NUM_T: begin
                w_a = r_q2;
                w_b = r_c;
            end
            ST_NUM: begin
                w_a = r_q2;
                w_b = r_q2;
            end
            ST_DEN_T: begin
                w_a = r_q1;
                w_b = r_c;
            end
            ST_DEN: begin
                w_a = r_q1;
                w_b = r_q1;
            end
            ST_R_NUM: begin
                w_a = r_r;
                w_b = r_num;
            end
            ST_R_DEN: begin
                w_ctl.op = OP_DIV;
                w_a      = r_r;
                w_b      = r_den;
            end
            ST_M_UPD: begin
                w_a = r_m;
                w_b = r_r;
            end
            ST_Q1: begin
                w_a = r_q1;
                w_b = r_qq;
            end
            ST_Q2: begin
                w_a = r_q2;
                w_b = r_qq;
            end
            default: w_op_state = 1'b0;
        endcase
    end

    assign w_start = w_op_state && !r_issued;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_tol    <= TOL_RESET;
            r_limit  <= LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done)       r_issued <= 1'b0;
            else if (w_start) r_issued <= 1'b1;
            if (i_cfg_wr_en) begin
                case (t_reg_index'(i_cfg_index))
                    REG_TOLERANCE:  r_tol   <= i_cfg_data;
                    REG_ITER_LIMIT: r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                    default:        r_tol   <= r_tol;
                endcase
            end
            if (w_out_load)                        r_ovalid <= 1'b1;
            else if (r_ovalid && i_m_axis_tready)  r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_u        <= w_in_u;
                r_k        <= (w_in_k == '0) ? (W-1)'(1) : w_in_k;
                r_q        <= w_in_q;
                r_res_val  <= '0;
                r_res_stat <= STAT_NOME;
            end
            ST_ADIV: if (w_done) begin
                r_p32  <= w_p32;
                r_flip <= w_p32[31] ^ w_p32[30];
                r_z    <= CORDIC_W'($signed({w_p32[31] ^ w_p32[30] ^ w_p32[31], w_p32[30:0]}));
                r_x    <= CORDIC_GAIN_INV;
                r_y    <= '0;
                r_ccnt <= '0;
            end
            ST_COR_S: begin
                // last sine step loads the start of the cosine run
                if (w_cor_last) begin
                    r_s    <= w_s_conv;
                    r_flip <= w_p32_dbl[31] ^ w_p32_dbl[30];
                    r_z    <= CORDIC_W'($signed({w_p32_dbl[30], w_p32_dbl[30:0]}));
                    r_x    <= CORDIC_GAIN_INV;
                    r_y    <= '0;
                    r_ccnt <= '0;
                end else begin
                    r_x    <= w_x_nx;
                    r_y    <= w_y_nx;
                    r_z    <= w_z_nx;
                    r_ccnt <= r_ccnt + 1'b1;
                end
            end
            ST_COR_C: begin
                r_x    <= w_x_nx;
                r_y    <= w_y_nx;
                r_z    <= w_z_nx;
                r_ccnt <= r_ccnt + 1'b1;
                if (w_cor_last) r_c <= w_c_conv;
            end
            ST_M0A:   if (w_done) r_t <= w_res;
            ST_M0B:   if (w_done) r_m <= w_res;
            ST_QQ: if (w_done) begin
                r_qq <= w_res;
                r_q1 <= 64'(r_q);
                r_q2 <= w_res;
                r_n  <= '0;
            end
            ST_CHK: begin
                r_res_val  <= '0;
                r_res_stat <= STAT_NOCONV;
            end
            ST_R_DIV: if (w_done) r_r <= w_res;
            ST_R_SQ:  if (w_done) r_r <= w_res;
            ST_NUM_T: if (w_done) r_t <= w_res;
            ST_NUM:   if (w_done) r_num <= w_comb;
            ST_DEN_T: if (w_done) r_t <= w_res;
            ST_DEN:   if (w_done) r_den <= w_comb;
            ST_R_NUM: if (w_done) r_r <= w_res;
            ST_R_DEN: if (w_done) r_r <= w_res;
            ST_M_UPD: if (w_done) begin
                r_m <= w_res;
                if (w_conv) begin
                    r_res_val  <= w_m_clip[W-1:0];
                    r_res_stat <= STAT_OK;
                end
            end
            ST_Q1: if (w_done) r_q1 <= w_res;
            ST_Q2: if (w_done) begin
                r_q2 <= w_res;
                r_n  <= r_n + 1'b1;
            end
            ST_OUT: if (w_out_load) begin
                r_odata <= r_res_val;
                r_ostat <= r_res_stat;
            end
            default: r_n <= r_n;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = ODW'(r_odata);
    assign o_m_axis_tuser  = r_ostat;

    // checks
    `JSNP_ASSERT(a_done_issued, !w_done || r_issued, "unit finished an operation never issued")
    `JSNP_ASSERT_NEXT(a_accept_busy, w_accept, r_state != ST_IDLE, "item accepted but block stayed idle")
    `JSNP_ASSERT(a_fail_zero, !o_m_axis_tvalid || o_m_axis_tuser == STAT_OK || r_odata == '0, "failed result is not zero")

endmodule

`default_nettype wire

[bench/jacobi_sn_nome_product_tb.sv]
// ----------------------------------------------------------------------------
// jacobi_sn_nome_product_tb
// self-checking bench for the jacobi sn nome product block
// ----------------------------------------------------------------------------
// Items go in on the input stream with random gaps. Each accepted item is run
// through a bit-exact fixed-point model kept here (angle divide, cordic,
// nome product passes), and the expected sn value and status are queued. Each
// result item is compared field by field with the oldest entry. Registers are
// changed only with the block drained, over several settings incl. extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_sn_nome_product_tb;
    import jsnp_pkg::*;

    localparam longint ONE_Q  = longint'(1) << 30;
    localparam longint SAT_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int  STALL_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] sn;
        t_status     status;
    } t_sn_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [20:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [95:0] in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_data;
    logic [1:0]  out_user;

    // shadow copies of the block registers
    logic [20:0] tol_reg = 21'd4;
    logic [6:0]  limit_reg = 7'd100;

    t_sn_result  expected_sn[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    longint arctan_turn32[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    jacobi_sn_nome_product dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),   // argument_u, quarter_period, nome
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),  // sn_value
        .o_m_axis_tuser  (out_user)   // status
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point arithmetic of the block
    // ------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input longint a);
        return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    function automatic longint clamp_signed(input logic [63:0] m, input bit neg);
        longint r;
        r = (m > 64'(SAT_MAX)) ? SAT_MAX : longint'(m);
        return neg ? -r : r;
    endfunction

    function automatic longint mul_shift(input longint a, input longint b, input int s);
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> s;
        if (p[127:64] != 0) return clamp_signed('1, neg);
        return clamp_signed(p[63:0], neg);
    endfunction

    function automatic longint div_shift(input longint a, input longint b, input int s);
        logic [127:0] nq;
        logic [63:0]  ua, ub;
        bit neg;
        ua = magnitude(a);
        ub = magnitude(b);
        neg = (a < 0) != (b < 0);
        if (ub == 0) return ua == 0 ? 64'sd0 : clamp_signed('1, a < 0);
        nq = ({64'd0, ua} << s) / {64'd0, ub};
        if (nq[127:64] != 0) return clamp_signed('1, neg);
        return clamp_signed(nq[63:0], neg);
    endfunction

    // rotation cordic, phase 2^32 per turn, results in q2.30
    task automatic sin_cos(input logic [31:0] phase, output longint sv, output longint cv);
        longint x, y, z, dx, dy;
        bit flip;
        x = 652032874;
        y = 0;
        flip = ((phase + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (flip) phase = phase - 32'h8000_0000;
        z = longint'($signed(phase));
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_turn32[i];
            end else begin
                x += dx; y -= dy; z += arctan_turn32[i];
            end
        end
        sv = flip ? -y : y;
        cv = flip ? -x : x;
    endtask

    // sn(u,k) from the nome product with the current register values
    task automatic predict_sn(input logic [31:0] u_bits, input logic [30:0] k_bits,
                              input logic [31:0] q_bits, output t_sn_result res);
        longint u, q, k, s, c, m, qq, q1, q2, r, num, den, unused;
        logic [127:0] nq;
        logic [31:0]  phase;
        u = longint'($signed(u_bits));
        q = longint'($signed(q_bits));
        k = (k_bits == 0) ? 1 : longint'(k_bits);
        res.sn = '0;
        if (magnitude(q) >= 64'(ONE_Q)) begin
            res.status = STAT_NOME;
            return;
        end
        nq = ({64'd0, magnitude(u)} << 30) / {64'd0, 64'(k)};
        phase = nq[31:0];
        if (u < 0) phase = 32'd0 - phase;
        sin_cos(phase, s, unused);
        sin_cos(phase << 1, unused, c);
        m = mul_shift(mul_shift(s, k, 24), 683565276, 30);
        qq = mul_shift(q, q, 30);
        q1 = q;
        q2 = qq;
        for (int n = 0; n < int'(limit_reg); n++) begin
            r = div_shift(ONE_Q - q1, ONE_Q - q2, 30);
            r = mul_shift(r, r, 30);
            num = ONE_Q - 2 * mul_shift(q2, c, 30) + mul_shift(q2, q2, 30);
            den = ONE_Q - 2 * mul_shift(q1, c, 30) + mul_shift(q1, q1, 30);
            r = div_shift(mul_shift(r, num, 30), den, 30);
            m = mul_shift(m, r, 30);
            if (magnitude(ONE_Q - r) < 64'(tol_reg)) begin
                if (m > 64'sd2147483647) m = 64'sd2147483647;
                if (m < -64'sd2147483648) m = -64'sd2147483648;
                res.sn = m[31:0];
                res.status = STAT_OK;
                return;
            end
            q1 = mul_shift(q1, qq, 30);
            q2 = mul_shift(q2, qq, 30);
        end
        res.status = STAT_NOCONV;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [31:0] u, input logic [30:0] k, input logic [31:0] q);
        t_sn_result res;
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        repeat (gap) @(negedge i_clk);
        in_data = {1'b0, q, k, u};
        in_valid = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        predict_sn(u, k, q, res);
        expected_sn.push_back(res);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    // wait for every result, then leave the block time to settle
    task automatic drain;
        while (expected_sn.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [20:0] value);
        drain();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_TOLERANCE) tol_reg = value;
        else limit_reg = value[6:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes;
        send_item(32'h0000_0000, 31'h0100_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h1000_0000);
        send_item(32'h8000_0000, 31'h7FFF_FFFF, 32'hF000_0000);
        send_item(32'h0100_0000, 31'h0000_0000, 32'h0000_0001);
        send_item(32'hFF00_0000, 31'h0000_0001, 32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0000);
        send_item(32'h1234_5678, 31'h0194_2000, 32'h0800_0000);
        send_item(32'hEDCB_A988, 31'h0194_2000, 32'hF800_0000);
        // u equal to K or to -K: sin(m) is plus or minus one, large K saturates the result
        send_item(32'h7F00_0000, 31'h7F00_0000, 32'h0100_0000);
        send_item(32'h8100_0000, 31'h7F00_0000, 32'h0100_0000);
    endtask

    task automatic test_nome_bounds;
        send_item(32'h0100_0000, 31'h0200_0000, 32'h4000_0000);
        send_item(32'h0100_0000, 31'h0200_0000, 32'hC000_0000);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h7FFF_FFFF);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h8000_0000);
        // nome just inside the unit circle, slow to converge
        send_item(32'h0080_0000, 31'h0300_0000, 32'h3FFF_FFFF);
        send_item(32'h0080_0000, 31'h0300_0000, 32'hC000_0001);
    endtask

    task automatic test_register_extremes;
        write_reg(REG_ITER_LIMIT, 21'd0);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h0100_0000);
        write_reg(REG_ITER_LIMIT, 21'd1);
        write_reg(REG_TOLERANCE, 21'd0);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h0100_0000);
        write_reg(REG_TOLERANCE, 21'd1048576);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h0100_0000);
        send_item(32'hFE00_0000, 31'h0180_0000, 32'h2000_0000);
        write_reg(REG_TOLERANCE, 21'd1);
        write_reg(REG_ITER_LIMIT, 21'd100);
        send_item(32'h0100_0000, 31'h0200_0000, 32'h0100_0000);
    endtask

    // random items, mostly small nomes so the product converges quickly
    task automatic test_random_items(input logic [20:0] tol, input logic [6:0] lim,
                                     input int count);
        logic [31:0] u, q;
        logic [30:0] k;
        int kind;
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_ITER_LIMIT, 21'(lim));
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            u = $urandom();
            k = 31'($urandom());
            if (kind < 6) begin
                k = 31'($urandom_range(32'h0040_0000, 32'h0400_0000));
                u = 32'($signed($urandom_range(0, 2 * int'(k)))) - 32'(k);
                q = 32'($urandom()) >> $urandom_range(4, 31);
                if ($urandom_range(0, 1)) q = 32'd0 - q;
            end else if (kind < 8 || lim > 40) begin
                // out of the unit circle or full random fields
                q = $urandom() | 32'h4000_0000;
                if ($urandom_range(0, 1)) q = {1'b1, ~q[30], q[29:0]};
            end else begin
                q = $urandom();
            end
            send_item(u, k, q);
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result receiver
    // ------------------------------------------------------------------
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            out_ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            out_ready = 1'b1;
            do @(posedge i_clk); while (!(out_valid && i_rst_n));
            @(negedge i_clk);
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_sn_result want;
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready) begin
                if (expected_sn.size() == 0) begin
                    report_mismatch("unexpected result", out_data, 32'(out_user));
                end else begin
                    want = expected_sn.pop_front();
                    if (out_data != want.sn) report_mismatch("sn_value", out_data, want.sn);
                    if (out_user != want.status)
                        report_mismatch("status", 32'(out_user), 32'(want.status));
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_field_extremes();
        test_nome_bounds();
        test_register_extremes();
        test_random_items(21'd4, 7'd100, 150);
        test_random_items(21'd1, 7'd12, 150);
        test_random_items(21'd1048576, 7'd1, 150);
        test_random_items(21'd300, 7'd40, 150);
        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_sn.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/jsnp_pkg.sv
rtl/jsnp_arith.sv
rtl/jacobi_sn_nome_product.sv
bench/jacobi_sn_nome_product_tb.sv
